FILE: sv/csvt_pkg.sv
// Package for the CSV field tokenizer: result kinds, register indexes,
// fixed byte codes and the tokenizer state record. No dependencies.
package csvt_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_CELL     = 2'd1,
      KIND_CELL_ROW = 2'd2,
      KIND_ROW      = 2'd3
   } kind_type;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE     = 1'd1;

   localparam logic [7:0] SEPARATOR_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;
   localparam logic [7:0] BYTE_CR         = 8'd13;
   localparam logic [7:0] BYTE_LF         = 8'd10;

   typedef struct packed {
      logic at_cell_start;
      logic quote_odd;
      logic cell_nonempty;
      logic row_has_cells;
      logic stream_done;
   } tok_state_type;

   localparam tok_state_type TOK_STATE_RESET = '{
      at_cell_start: 1'b1,
      quote_odd:     1'b0,
      cell_nonempty: 1'b0,
      row_has_cells: 1'b0,
      stream_done:   1'b0
   };

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] ch;
   } tok_result_type;

endpackage

FILE: sv/csvt_decode.sv
// Per-word decode of the tokenizer: next state and optional result from the
// current state, one input word and the separator and quote bytes. Uses csvt_pkg.
module csvt_decode
   import csvt_pkg::*;
(
   input  tok_state_type  state_cur,
   input  logic [7:0]     in_byte,
   input  logic           in_end,
   input  logic [7:0]     separator_char,
   input  logic [7:0]     quote_char,
   output tok_state_type  state_nxt,
   output tok_result_type result
);

   always_comb begin
      logic is_break;
      logic is_quote;
      logic is_sep;
      logic handled;
      is_break  = (in_byte == BYTE_CR) || (in_byte == BYTE_LF);
      is_quote  = (in_byte == quote_char);
      is_sep    = (in_byte == separator_char);
      handled   = 1'b0;
      state_nxt = state_cur;
      result    = '{valid: 1'b0, kind: KIND_CHAR, ch: 8'd0};

      if (state_cur.stream_done) begin
         handled = 1'b1;
      end else if (in_end) begin
         handled = 1'b1;
         if (state_cur.cell_nonempty) begin
            result.valid = 1'b1;
            result.kind  = KIND_CELL_ROW;
         end else if (state_cur.row_has_cells) begin
            result.valid = 1'b1;
            result.kind  = KIND_ROW;
         end
         state_nxt             = TOK_STATE_RESET;
         state_nxt.stream_done = 1'b1;
      end else if (state_cur.at_cell_start) begin
         // skip leading line breaks; swallow an opening quote
         if (is_break) begin
            handled = 1'b1;
         end else begin
            state_nxt.at_cell_start = 1'b0;
            if (is_quote) begin
               state_nxt.quote_odd = 1'b1;
               handled             = 1'b1;
            end
         end
      end

      if (!handled) begin
         if (is_quote) begin
            state_nxt.quote_odd = !state_cur.quote_odd;
            if (!state_cur.quote_odd) begin
               result.valid            = 1'b1;
               result.ch               = in_byte;
               state_nxt.cell_nonempty = 1'b1;
            end
         end else if (is_sep) begin
            result.valid = 1'b1;
            if (state_cur.quote_odd) begin
               result.ch               = in_byte;
               state_nxt.cell_nonempty = 1'b1;
            end else begin
               result.kind             = KIND_CELL;
               state_nxt               = TOK_STATE_RESET;
               state_nxt.row_has_cells = 1'b1;
            end
         end else if (is_break) begin
            result.valid = 1'b1;
            result.kind  = KIND_CELL_ROW;
            state_nxt    = TOK_STATE_RESET;
         end else begin
            result.valid            = 1'b1;
            result.ch               = in_byte;
            state_nxt.cell_nonempty = 1'b1;
         end
      end
   end

endmodule

FILE: sv/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: input register, state and
// configuration registers, result register. Uses csvt_pkg and csvt_decode.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata = in_byte, tlast = end_of_input
//   rsp     | out | rsp_tvalid/tready    | tdata = out_char, tuser = out_kind
//   csr     | in  | csr_wen              | csr_idx, csr_wdata
//
// One word per cycle unless back-pressure on rsp stalls it. A word is registered
// in the input register, decoded there, and its result (if any) lands in the
// result register. Reset is synchronous, active high, and restores the default
// separator and quote bytes. When rsp_tready is low and the result register
// is full, the input register holds and req_tready drops once it is full too.
module csv_field_tokenizer_top
   import csvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] in_byte
   input  logic                 req_tlast,   // end_of_input
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_char
   output logic [1:0]           rsp_tuser,   // [1:0] out_kind
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [7:0]           csr_wdata
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_end_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [7:0]     out_char_ff;
   kind_type       out_kind_ff;
   logic [7:0]     sep_ff;
   logic [7:0]     quote_ff;
   tok_state_type  state_ff;
   tok_state_type  state_in;
   tok_result_type result;
   logic           advance;
   logic           fire;

   csvt_decode u_decode (
      .state_cur      (state_ff),
      .in_byte        (in_byte_ff),
      .in_end         (in_end_ff),
      .separator_char (sep_ff),
      .quote_char     (quote_ff),
      .state_nxt      (state_in),
      .result         (result)
   );

   // the stage moves when the result register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (fire && result.valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= TOK_STATE_RESET;
         sep_ff       <= SEPARATOR_RESET;
         quote_ff     <= QUOTE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_wen) begin
            case (csr_idx)
               CSR_SEPARATOR: sep_ff   <= csr_wdata;
               CSR_QUOTE:     quote_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (fire && result.valid) begin
         out_char_ff <= result.ch;
         out_kind_ff <= result.kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule
